### rtl/core/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg
// Types, field widths and constants shared by the deauth frame monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package dfm_pkg;

   localparam int TOP_CHANNEL = 13;

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [15:0] RST_HOP_INTERVAL = 16'd1500;
   localparam logic [15:0] RST_AVG_INTERVAL = 16'd1000;
   localparam logic [15:0] RST_DEBOUNCE = 16'd200;
   localparam logic [7:0] RST_MIN_HEADER = 8'd24;

   localparam logic [7:0] FC_TYPE_MASK = 8'hFC;
   localparam logic [7:0] FC_DEAUTH = 8'hC0;

   typedef enum logic [1:0] {
      OP_MGMT_FRAME  = 2'd0,
      OP_OTHER_FRAME = 2'd1,
      OP_MS_TICK     = 2'd2,
      OP_MODE_PRESS  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOP_INTERVAL = 2'd0,
      CSR_AVG_INTERVAL = 2'd1,
      CSR_DEBOUNCE     = 2'd2,
      CSR_MIN_HEADER   = 2'd3
   } csr_index_type;

   function automatic logic [3:0] main_channel(input logic [1:0] idx);
      logic [3:0] ch;
      case (idx)
         2'd0:    ch = 4'd1;
         2'd1:    ch = 4'd6;
         2'd2:    ch = 4'd11;
         default: ch = 4'd1;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/core/deauth_frame_monitor_core.sv
// ----------------------------------------------------------------------------
// deauth_frame_monitor_core
// Counts 802.11 deauth frames, hops channels on ms ticks and keeps a
// periodic RSSI average through a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit up)                          tuser
//  req_     in   frame_control, transmitter_addr, rssi, frame_length  opcode
//  rsp_     out  channel, all_channels_mode, channel_count,           -
//                total_count, last_sender, last_sender_channel,
//                sender_seen, average_rssi, retune
//  csr_     in   write enable, index, 16-bit data                      -
//
//  an item goes from IDLE to EMIT, or first through the 32-step restoring divider in
//  DIV on a tick that updates the average with samples present
//  one item at a time; ready is low from accept until its result is loaded
//  the result register frees the input side while it waits for rsp_tready
//  reset is synchronous and restores all counters but not the divider and response data registers
// ----------------------------------------------------------------------------
`default_nettype none

module deauth_frame_monitor_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // frame_control, transmitter_addr, rssi, frame_length, zero pad
   input  wire logic [dfm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  wire logic [dfm_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // channel, all_channels_mode, channel_count, total_count, last_sender,
   // last_sender_channel, sender_seen, average_rssi, retune, zero pad
   output logic [dfm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [dfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dfm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dfm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] hop_interval_ff, avg_interval_ff, debounce_ff;
   logic [7:0]  min_header_ff;

   logic        sweep_ff, sweep_in;
   logic [1:0]  main_idx_ff, main_idx_in;
   logic [3:0]  chan_ff, chan_in;
   logic [15:0] chan_hits_ff, chan_hits_in;
   logic [15:0] all_hits_ff, all_hits_in;
   logic [47:0] sender_ff, sender_in;
   logic [3:0]  sender_chan_ff, sender_chan_in;
   logic        seen_ff, seen_in;
   logic [31:0] sum_ff, sum_in;
   logic [15:0] samples_ff, samples_in;
   logic [7:0]  shown_ff, shown_in;
   logic [15:0] hop_el_ff, hop_el_in;
   logic [15:0] avg_el_ff, avg_el_in;
   logic [15:0] press_el_ff, press_el_in;
   logic        retune_ff, retune_in;

   logic [31:0]          quo_ff, quo_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   opcode_type  op;
   logic [15:0] fc;
   logic [47:0] addr;
   logic [7:0]  rssi;
   logic [11:0] flen;
   logic        accept;
   logic        is_deauth;
   logic [15:0] hop_inc, avg_inc, press_inc;
   logic [4:0]  next_chan;
   logic [16:0] trial;
   logic [16:0] trial_diff;
   logic [31:0] quo_signed;

   assign op     = opcode_type'(req_tuser);
   assign fc     = req_tdata[15:0];
   assign addr   = req_tdata[63:16];
   assign rssi   = req_tdata[71:64];
   assign flen   = req_tdata[83:72];
   assign accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_deauth = (flen >= {4'd0, min_header_ff})
                      && ((fc[7:0] & FC_TYPE_MASK) == FC_DEAUTH);
   assign hop_inc   = (hop_el_ff == 16'hFFFF) ? hop_el_ff : hop_el_ff + 16'd1;
   assign avg_inc   = (avg_el_ff == 16'hFFFF) ? avg_el_ff : avg_el_ff + 16'd1;
   assign press_inc = (press_el_ff == 16'hFFFF) ? press_el_ff : press_el_ff + 16'd1;
   assign next_chan = {1'b0, chan_ff} + 5'd1;

   assign trial      = {rem_ff, quo_ff[31]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign quo_signed = neg_ff ? (32'd0 - quo_in) : quo_in;

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      main_idx_in    = main_idx_ff;
      chan_in        = chan_ff;
      chan_hits_in   = chan_hits_ff;
      all_hits_in    = all_hits_ff;
      sender_in      = sender_ff;
      sender_chan_in = sender_chan_ff;
      seen_in        = seen_ff;
      sum_in         = sum_ff;
      samples_in     = samples_ff;
      shown_in       = shown_ff;
      hop_el_in      = hop_el_ff;
      avg_el_in      = avg_el_ff;
      press_el_in    = press_el_ff;
      retune_in      = retune_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      neg_in         = neg_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_EMIT;
               retune_in = 1'b0;
               case (op)
                  OP_MGMT_FRAME: begin
                     if (is_deauth) begin
                        sender_in      = addr;
                        sender_chan_in = chan_ff;
                        sum_in         = sum_ff + {{24{rssi[7]}}, rssi};
                        samples_in     = samples_ff + 16'd1;
                        seen_in        = 1'b1;
                        chan_hits_in   = chan_hits_ff + 16'd1;
                        all_hits_in    = all_hits_ff + 16'd1;
                     end
                  end
                  OP_MS_TICK: begin
                     press_el_in = press_inc;
                     hop_el_in   = hop_inc;
                     avg_el_in   = avg_inc;
                     if (hop_inc >= hop_interval_ff) begin
                        if (!sweep_ff) begin
                           main_idx_in = (main_idx_ff >= 2'd2) ? 2'd0 : main_idx_ff + 2'd1;
                           chan_in     = main_channel(main_idx_in);
                        end else begin
                           chan_in = (next_chan > 5'(TOP_CHANNEL)) ? 4'd1 : next_chan[3:0];
                        end
                        chan_hits_in = 16'd0;
                        hop_el_in    = 16'd0;
                        retune_in    = 1'b1;
                     end
                     if (avg_inc >= avg_interval_ff) begin
                        avg_el_in = 16'd0;
                        if (samples_ff != 16'd0) begin
                           neg_in     = sum_ff[31];
                           quo_in     = sum_ff[31] ? (32'd0 - sum_ff) : sum_ff;
                           rem_in     = 16'd0;
                           divisor_in = samples_ff;
                           cnt_in     = '0;
                           sum_in     = 32'd0;
                           samples_in = 16'd0;
                           state_in   = S_DIV;
                        end
                     end
                  end
                  OP_MODE_PRESS: begin
                     if (press_el_ff > debounce_ff) begin
                        sweep_in     = !sweep_ff;
                        main_idx_in  = 2'd0;
                        chan_in      = 4'd1;
                        chan_hits_in = 16'd0;
                        press_el_in  = 16'd0;
                        retune_in    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (!trial_diff[16]) begin
               rem_in = trial_diff[15:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               shown_in = quo_signed[7:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, retune_ff, shown_ff, seen_ff, sender_chan_ff,
                               sender_ff, all_hits_ff, chan_hits_ff, sweep_ff, chan_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         hop_interval_ff <= RST_HOP_INTERVAL;
         avg_interval_ff <= RST_AVG_INTERVAL;
         debounce_ff     <= RST_DEBOUNCE;
         min_header_ff   <= RST_MIN_HEADER;
         sweep_ff        <= 1'b0;
         main_idx_ff     <= 2'd0;
         chan_ff         <= 4'd1;
         chan_hits_ff    <= 16'd0;
         all_hits_ff     <= 16'd0;
         sender_ff       <= 48'd0;
         sender_chan_ff  <= 4'd0;
         seen_ff         <= 1'b0;
         sum_ff          <= 32'd0;
         samples_ff      <= 16'd0;
         shown_ff        <= 8'd0;
         hop_el_ff       <= 16'd0;
         avg_el_ff       <= 16'd0;
         press_el_ff     <= 16'hFFFF;
         retune_ff       <= 1'b0;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         main_idx_ff    <= main_idx_in;
         chan_ff        <= chan_in;
         chan_hits_ff   <= chan_hits_in;
         all_hits_ff    <= all_hits_in;
         sender_ff      <= sender_in;
         sender_chan_ff <= sender_chan_in;
         seen_ff        <= seen_in;
         sum_ff         <= sum_in;
         samples_ff     <= samples_in;
         shown_ff       <= shown_in;
         hop_el_ff      <= hop_el_in;
         avg_el_ff      <= avg_el_in;
         press_el_ff    <= press_el_in;
         retune_ff      <= retune_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_HOP_INTERVAL: hop_interval_ff <= csr_wdata;
               CSR_AVG_INTERVAL: avg_interval_ff <= csr_wdata;
               CSR_DEBOUNCE:     debounce_ff     <= csr_wdata;
               CSR_MIN_HEADER:   min_header_ff   <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff >= 4'd1 && chan_ff <= 4'(TOP_CHANNEL))
      else $error("tuned channel out of range");

   a_main_set: assert property (@(posedge clock) disable iff (reset)
      !sweep_ff |-> (chan_ff == 4'd1 || chan_ff == 4'd6 || chan_ff == 4'd11))
      else $error("main mode off the main channel set");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("item accepted while one is in flight");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |=> state_ff == S_EMIT)
      else $error("divider did not finish after its last step");

   a_none_seen: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (all_hits_ff == 16'd0 && sender_chan_ff == 4'd0 && samples_ff == 16'd0))
      else $error("hit state set before any deauth item");
`endif

endmodule

`default_nettype wire
